### hw/rtl/nnr_pkg.sv
package nnr_pkg;

    localparam int CFG_W     = 9;
    localparam int BPP_W     = 3;
    localparam int PIX_W     = 32;
    localparam int CFG_IDX_W = 3;

    localparam int DEF_MAX_WIDTH           = 256;
    localparam int DEF_MAX_HEIGHT          = 256;
    localparam int DEF_MAX_BYTES_PER_PIXEL = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 3'd4;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_ARG = 1'b1;

    // per-axis source index tracker: q = ceil(pos*(src-1)/span), e = q*span - pos*(src-1)
    typedef struct packed {
        logic [CFG_W-1:0] q;
        logic [CFG_W-1:0] e;
    } axis_t;

endpackage

### hw/rtl/nnr_ram.sv
module nnr_ram #(
    parameter int DW = 32,
    parameter int DEPTH = 65536,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/nnr_div.sv
module nnr_div #(
    parameter int W = nnr_pkg::CFG_W,
    localparam int CNT_W = $clog2(W + 1)
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         busy,
    output logic [W-1:0] quot,
    output logic [W-1:0] rem
);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     quot_reg, quot_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     dvs_reg, dvs_next;
    logic [W:0]       trial;
    logic [W:0]       diff;

    // restoring division, one quotient bit per cycle
    always_comb begin
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quot_reg[W-1]};
        diff      = trial - {1'b0, dvs_reg};
        if (start) begin
            cnt_next  = CNT_W'(W);
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next  = diff[W-1:0];
                quot_next = {quot_reg[W-2:0], 1'b1};
            end else begin
                rem_next  = trial[W-1:0];
                quot_next = {quot_reg[W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign busy = (cnt_reg != '0);
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

### hw/rtl/nearest_neighbor_resize_top.sv
// Fetch request: the store read is registered at the accepting edge, and the output register
// takes the result once it is empty or m_ready is high.
// Throughput: one request per cycle, writes and fetches alike, when not held off or stalled.
// After reset and after each write to a defined register, input is held off while two
// 9-step dividers form the per-pixel source index steps; register writes are taken anytime.
// Reset clears pointers, position and registers (to 1); frame store contents are not cleared.
module nearest_neighbor_resize_top #(
    parameter int MAX_WIDTH           = nnr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT          = nnr_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_BYTES_PER_PIXEL = nnr_pkg::DEF_MAX_BYTES_PER_PIXEL
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [nnr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nnr_pkg::CFG_W-1:0]      cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_opcode,
    input  logic [nnr_pkg::PIX_W-1:0]      s_source_pixel,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [nnr_pkg::PIX_W-1:0]      m_dest_pixel,
    output logic                           m_status,
    output logic                           m_last_of_frame
);

    localparam int CFG_W = nnr_pkg::CFG_W;
    localparam int PIX_W = nnr_pkg::PIX_W;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int WP_W  = AW + 1;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int CCMP_W = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int RCMP_W = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;
    localparam int PROD_W = 2 * CFG_W + 1;
    localparam int NBYTES = PIX_W / 8;

    // configuration
    logic [CFG_W-1:0]         src_width_reg, src_width_next;
    logic [CFG_W-1:0]         src_height_reg, src_height_next;
    logic [CFG_W-1:0]         dst_width_reg, dst_width_next;
    logic [CFG_W-1:0]         dst_height_reg, dst_height_next;
    logic [nnr_pkg::BPP_W-1:0] bpp_reg, bpp_next;
    logic                     cfg_hit;
    logic                     cal_go_reg, cal_go_next;

    // frame position
    logic [WP_W-1:0]          wp_reg, wp_next;
    logic [CW-1:0]            col_reg, col_next;
    logic [RW-1:0]            row_reg, row_next;
    nnr_pkg::axis_t           colx_reg, colx_next, colx_step;
    nnr_pkg::axis_t           rowx_reg, rowx_next, rowx_step;

    // read and output stages
    logic                     rd_pend_reg, rd_pend_next;
    logic                     pend_status_reg;
    logic                     pend_last_reg;
    logic [PIX_W-1:0]         pend_mask_reg;
    logic                     out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]         out_pixel_reg;
    logic                     out_status_reg;
    logic                     out_last_reg;

    logic                     acc, wr_acc, fe_acc, mv;
    logic                     args_ok, wrap_c, wrap_r, store_full;
    logic [CFG_W-1:0]         span_c, span_r;
    logic [CFG_W-1:0]         dc, rc, dr, rr;
    logic                     busy_c, busy_r;
    logic [PROD_W-1:0]        addr_full;
    logic [PIX_W-1:0]         byte_mask;
    logic [PIX_W-1:0]         ram_q;

    function automatic nnr_pkg::axis_t axis_step(nnr_pkg::axis_t cur,
                                                 logic [CFG_W-1:0] d,
                                                 logic [CFG_W-1:0] r,
                                                 logic [CFG_W-1:0] span);
        nnr_pkg::axis_t nx;
        // step = d*span + r; carry into the quotient when r exceeds the slack e
        if (r > cur.e) begin
            nx.q = cur.q + d + CFG_W'(1);
            nx.e = span - (r - cur.e);
        end else begin
            nx.q = cur.q + d;
            nx.e = cur.e - r;
        end
        return nx;
    endfunction

    assign span_c = dst_width_reg - CFG_W'(1);
    assign span_r = dst_height_reg - CFG_W'(1);

    nnr_div #(.W(CFG_W)) u_div_col (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cal_go_reg),
        .dividend (src_width_reg - CFG_W'(1)),
        .divisor  (span_c),
        .busy     (busy_c),
        .quot     (dc),
        .rem      (rc)
    );

    nnr_div #(.W(CFG_W)) u_div_row (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cal_go_reg),
        .dividend (src_height_reg - CFG_W'(1)),
        .divisor  (span_r),
        .busy     (busy_r),
        .quot     (dr),
        .rem      (rr)
    );

    assign mv      = rd_pend_reg && (!out_valid_reg || m_ready);
    assign s_ready = !cal_go_reg && !busy_c && !busy_r
                     && !(rd_pend_reg && out_valid_reg && !m_ready);
    assign acc     = s_valid && s_ready;
    assign wr_acc  = acc && (s_opcode == nnr_pkg::OP_WRITE);
    assign fe_acc  = acc && (s_opcode == nnr_pkg::OP_FETCH);

    assign args_ok = (src_width_reg != '0) && (src_height_reg != '0)
                     && (dst_width_reg != '0) && (dst_height_reg != '0)
                     && (int'(src_width_reg) <= MAX_WIDTH)
                     && (int'(dst_width_reg) <= MAX_WIDTH)
                     && (int'(src_height_reg) <= MAX_HEIGHT)
                     && (int'(dst_height_reg) <= MAX_HEIGHT)
                     && (bpp_reg != '0)
                     && (int'(bpp_reg) <= MAX_BYTES_PER_PIXEL);

    assign wrap_c = (CCMP_W'(col_reg) + CCMP_W'(1)) >= CCMP_W'(dst_width_reg);
    assign wrap_r = (RCMP_W'(row_reg) + RCMP_W'(1)) >= RCMP_W'(dst_height_reg);
    assign store_full = (wp_reg >= WP_W'(DEPTH));

    assign colx_step = axis_step(colx_reg, dc, rc, span_c);
    assign rowx_step = axis_step(rowx_reg, dr, rr, span_r);

    assign addr_full = PROD_W'(rowx_reg.q) * PROD_W'(src_width_reg) + PROD_W'(colx_reg.q);

    always_comb begin
        for (int i = 0; i < NBYTES; i++) begin
            byte_mask[8*i +: 8] = (int'(bpp_reg) > i) ? 8'hFF : 8'h00;
        end
    end

    always_comb begin
        src_width_next  = src_width_reg;
        src_height_next = src_height_reg;
        dst_width_next  = dst_width_reg;
        dst_height_next = dst_height_reg;
        bpp_next        = bpp_reg;
        cfg_hit         = 1'b0;
        if (cfg_wr_en) begin
            case (cfg_index)
                nnr_pkg::REG_SRC_WIDTH: begin
                    src_width_next = cfg_wr_data;
                    cfg_hit = 1'b1;
                end
                nnr_pkg::REG_SRC_HEIGHT: begin
                    src_height_next = cfg_wr_data;
                    cfg_hit = 1'b1;
                end
                nnr_pkg::REG_DST_WIDTH: begin
                    dst_width_next = cfg_wr_data;
                    cfg_hit = 1'b1;
                end
                nnr_pkg::REG_DST_HEIGHT: begin
                    dst_height_next = cfg_wr_data;
                    cfg_hit = 1'b1;
                end
                nnr_pkg::REG_BYTES_PER_PIXEL: begin
                    bpp_next = cfg_wr_data[nnr_pkg::BPP_W-1:0];
                    cfg_hit = 1'b1;
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
        cal_go_next = cfg_hit;
    end

    always_comb begin
        wp_next   = wp_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        colx_next = colx_reg;
        rowx_next = rowx_reg;
        if (cfg_hit) begin
            wp_next   = '0;
            col_next  = '0;
            row_next  = '0;
            colx_next = '0;
            rowx_next = '0;
        end else begin
            if (wr_acc && !store_full) begin
                wp_next = wp_reg + WP_W'(1);
            end
            if (fe_acc && args_ok) begin
                if (wrap_c) begin
                    col_next  = '0;
                    colx_next = '0;
                    if (wrap_r) begin
                        row_next  = '0;
                        rowx_next = '0;
                    end else begin
                        row_next  = row_reg + RW'(1);
                        rowx_next = rowx_step;
                    end
                end else begin
                    col_next  = col_reg + CW'(1);
                    colx_next = colx_step;
                end
            end
        end
    end

    always_comb begin
        rd_pend_next = rd_pend_reg;
        if (fe_acc) begin
            rd_pend_next = 1'b1;
        end else if (mv) begin
            rd_pend_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (mv) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    nnr_ram #(.DW(PIX_W), .DEPTH(DEPTH)) u_store (
        .aclk    (aclk),
        .wr_en   (wr_acc && !store_full),
        .wr_addr (wp_reg[AW-1:0]),
        .wr_data (s_source_pixel),
        .rd_en   (fe_acc),
        .rd_addr (AW'(addr_full)),
        .rd_data (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= CFG_W'(1);
            src_height_reg <= CFG_W'(1);
            dst_width_reg  <= CFG_W'(1);
            dst_height_reg <= CFG_W'(1);
            bpp_reg        <= nnr_pkg::BPP_W'(1);
            cal_go_reg     <= 1'b1;
            wp_reg         <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            colx_reg       <= '0;
            rowx_reg       <= '0;
            rd_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            src_width_reg  <= src_width_next;
            src_height_reg <= src_height_next;
            dst_width_reg  <= dst_width_next;
            dst_height_reg <= dst_height_next;
            bpp_reg        <= bpp_next;
            cal_go_reg     <= cal_go_next;
            wp_reg         <= wp_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            colx_reg       <= colx_next;
            rowx_reg       <= rowx_next;
            rd_pend_reg    <= rd_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fe_acc) begin
            pend_status_reg <= args_ok ? nnr_pkg::STATUS_OK : nnr_pkg::STATUS_BAD_ARG;
            pend_last_reg   <= args_ok && wrap_c && wrap_r;
            pend_mask_reg   <= args_ok ? byte_mask : '0;
        end
        if (mv) begin
            out_pixel_reg  <= ram_q & pend_mask_reg;
            out_status_reg <= pend_status_reg;
            out_last_reg   <= pend_last_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_dest_pixel    = out_pixel_reg;
    assign m_status        = out_status_reg;
    assign m_last_of_frame = out_last_reg;

endmodule

### tb/sv/nearest_neighbor_resize_checker.sv
module nearest_neighbor_resize_checker
    import nnr_pkg::*;
#(
    parameter int MAX_WIDTH           = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT          = DEF_MAX_HEIGHT,
    parameter int MAX_BYTES_PER_PIXEL = DEF_MAX_BYTES_PER_PIXEL
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic                 s_opcode,
    input  logic [PIX_W-1:0]     s_source_pixel,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [PIX_W-1:0]     m_dest_pixel,
    input  logic                 m_status,
    input  logic                 m_last_of_frame,
    output int unsigned          fail_count,
    output int unsigned          pixels_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             status;
        logic             last;
    } dest_pixel_t;

    logic [PIX_W-1:0] frame_mem [STORE_DEPTH];
    dest_pixel_t      dest_q [$];
    int unsigned      wr_ptr;
    int unsigned      out_row;
    int unsigned      out_col;
    logic [CFG_W-1:0] src_w;
    logic [CFG_W-1:0] src_h;
    logic [CFG_W-1:0] dst_w;
    logic [CFG_W-1:0] dst_h;
    logic [BPP_W-1:0] bpp;
    int unsigned      errs = 0;

    // ceil(pos*(src-1)/(dst-1)), clamped; a one-pixel destination maps to 0
    function automatic int unsigned source_index(int unsigned pos, int unsigned src_n,
                                                 int unsigned dst_n);
        int unsigned q;
        if (dst_n <= 1)
            return 0;
        q = (pos * (src_n - 1) + dst_n - 2) / (dst_n - 1);
        return (q >= src_n) ? src_n - 1 : q;
    endfunction

    function automatic bit frame_valid();
        return src_w != 0 && src_h != 0 && dst_w != 0 && dst_h != 0
            && src_w <= MAX_WIDTH && dst_w <= MAX_WIDTH
            && src_h <= MAX_HEIGHT && dst_h <= MAX_HEIGHT
            && bpp != 0 && bpp <= MAX_BYTES_PER_PIXEL;
    endfunction

    // next destination pixel; steps the output position when the frame is valid
    function automatic dest_pixel_t resize_fetch();
        dest_pixel_t      r;
        int unsigned      sx;
        int unsigned      sy;
        int unsigned      addr;
        logic [PIX_W-1:0] mask;
        r = '0;
        if (!frame_valid()) begin
            r.status = STATUS_BAD_ARG;
            return r;
        end
        sx   = source_index(out_col, src_w, dst_w);
        sy   = source_index(out_row, src_h, dst_h);
        addr = sy * src_w + sx;
        mask = (bpp >= 4) ? '1 : ((PIX_W'(1) << (8 * bpp)) - PIX_W'(1));
        r.pixel  = (addr < STORE_DEPTH) ? (frame_mem[addr] & mask) : '0;
        r.status = STATUS_OK;
        r.last   = (out_col + 1 >= dst_w) && (out_row + 1 >= dst_h);
        if (out_col + 1 >= dst_w) begin
            out_col = 0;
            out_row = (out_row + 1 >= dst_h) ? 0 : out_row + 1;
        end else begin
            out_col++;
        end
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        dest_pixel_t want;
        bit          known_reg;
        if (!aresetn) begin
            wr_ptr  = 0;
            out_row = 0;
            out_col = 0;
            src_w   = CFG_W'(1);
            src_h   = CFG_W'(1);
            dst_w   = CFG_W'(1);
            dst_h   = CFG_W'(1);
            bpp     = BPP_W'(1);
            dest_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (dest_q.size() == 0) begin
                    errs++;
                    $display("%0t unexpected dest pixel: expected none actual %08h/%0b/%0b",
                             $time, m_dest_pixel, m_status, m_last_of_frame);
                end else begin
                    want = dest_q.pop_front();
                    if (m_dest_pixel !== want.pixel) begin
                        errs++;
                        $display("%0t dest_pixel: expected %08h actual %08h",
                                 $time, want.pixel, m_dest_pixel);
                    end
                    if (m_status !== want.status) begin
                        errs++;
                        $display("%0t status: expected %0b actual %0b",
                                 $time, want.status, m_status);
                    end
                    if (m_last_of_frame !== want.last) begin
                        errs++;
                        $display("%0t last_of_frame: expected %0b actual %0b",
                                 $time, want.last, m_last_of_frame);
                    end
                end
            end

            if (cfg_wr_en) begin
                known_reg = 1'b1;
                case (cfg_index)
                    REG_SRC_WIDTH:       src_w = cfg_wr_data;
                    REG_SRC_HEIGHT:      src_h = cfg_wr_data;
                    REG_DST_WIDTH:       dst_w = cfg_wr_data;
                    REG_DST_HEIGHT:      dst_h = cfg_wr_data;
                    REG_BYTES_PER_PIXEL: bpp = cfg_wr_data[BPP_W-1:0];
                    default:             known_reg = 1'b0;
                endcase
                // any real register write starts a new frame; store is kept
                if (known_reg) begin
                    wr_ptr  = 0;
                    out_row = 0;
                    out_col = 0;
                end
            end

            if (s_valid && s_ready) begin
                if (s_opcode == OP_WRITE) begin
                    if (wr_ptr < STORE_DEPTH) begin
                        frame_mem[wr_ptr] = s_source_pixel;
                        wr_ptr++;
                    end
                end else begin
                    dest_q.push_back(resize_fetch());
                end
            end
        end
        fail_count <= errs;
        pixels_due <= dest_q.size();
    end

endmodule

### tb/sv/nearest_neighbor_resize_top_tb.sv
module nearest_neighbor_resize_top_tb;
    import nnr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_W       = DEF_MAX_WIDTH;
    localparam int unsigned MAX_H       = DEF_MAX_HEIGHT;
    localparam int unsigned MAX_BPP     = DEF_MAX_BYTES_PER_PIXEL;
    localparam int unsigned STORE_DEPTH = MAX_W * MAX_H;
    localparam int unsigned RAND_ITEMS  = 850;
    localparam int unsigned SETTLE      = 6;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_SRC_WIDTH;
    logic [CFG_W-1:0]     cfg_wr_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_opcode = OP_WRITE;
    logic [PIX_W-1:0]     s_source_pixel = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [PIX_W-1:0]     m_dest_pixel;
    logic                 m_status;
    logic                 m_last_of_frame;

    int unsigned fail_count;
    int unsigned pixels_due;

    int unsigned gap_odds = 0;
    int unsigned stall_odds = 0;
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;

    // source pixels written since the last register write, and one past the
    // highest store address ever written (writes always fill the store from 0 up)
    int unsigned phase_wr = 0;
    int unsigned written_hi = 0;
    int unsigned frame_px = 1;
    bit          cfg_ok = 1'b1;
    int unsigned rand_items = 0;

    nearest_neighbor_resize_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_source_pixel  (s_source_pixel),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_dest_pixel    (m_dest_pixel),
        .m_status        (m_status),
        .m_last_of_frame (m_last_of_frame)
    );

    nearest_neighbor_resize_checker resize_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_source_pixel  (s_source_pixel),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_dest_pixel    (m_dest_pixel),
        .m_status        (m_status),
        .m_last_of_frame (m_last_of_frame),
        .fail_count      (fail_count),
        .pixels_due      (pixels_due)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result-side back-pressure, drawn at random with odds set by stall_odds
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 12);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_item(input logic op, input logic [PIX_W-1:0] pix);
        int unsigned gap;
        if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
            gap = $urandom_range(1, 13);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_opcode       <= op;
        s_source_pixel <= pix;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic put_pixel(input logic [PIX_W-1:0] pix);
        send_item(OP_WRITE, pix);
        if (phase_wr < STORE_DEPTH)
            phase_wr++;
        if (phase_wr > written_hi)
            written_hi = phase_wr;
    endtask

    task automatic take_pixel();
        send_item(OP_FETCH, $urandom);
    endtask

    // a fetch request only goes out once every source address it can hit was written
    task automatic issue(input bit want_fetch);
        if (want_fetch && (!cfg_ok || frame_px <= written_hi))
            take_pixel();
        else
            put_pixel($urandom);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pixels_due != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_frame(input int unsigned sw, input int unsigned sh,
                             input int unsigned dw, input int unsigned dh,
                             input logic [CFG_W-1:0] bpp_word);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_SRC_WIDTH;
        cfg_wr_data <= CFG_W'(sw);
        @(posedge aclk);
        cfg_index   <= REG_SRC_HEIGHT;
        cfg_wr_data <= CFG_W'(sh);
        @(posedge aclk);
        cfg_index   <= REG_DST_WIDTH;
        cfg_wr_data <= CFG_W'(dw);
        @(posedge aclk);
        cfg_index   <= REG_DST_HEIGHT;
        cfg_wr_data <= CFG_W'(dh);
        @(posedge aclk);
        cfg_index   <= REG_BYTES_PER_PIXEL;
        cfg_wr_data <= bpp_word;
        @(posedge aclk);
        // now and then an index past the register file, which must do nothing
        if ($urandom_range(0, 5) == 0) begin
            cfg_index   <= REG_BYTES_PER_PIXEL + CFG_IDX_W'($urandom_range(1, 3));
            cfg_wr_data <= CFG_W'($urandom);
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        phase_wr = 0;
        frame_px = sw * sh;
        cfg_ok   = sw >= 1 && sw <= MAX_W && sh >= 1 && sh <= MAX_H
                && dw >= 1 && dw <= MAX_W && dh >= 1 && dh <= MAX_H
                && bpp_word[BPP_W-1:0] >= 1 && bpp_word[BPP_W-1:0] <= MAX_BPP;
    endtask

    function automatic int unsigned bad_size();
        return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(MAX_W + 1, 511);
    endfunction

    task automatic random_phase();
        int unsigned          sw;
        int unsigned          sh;
        int unsigned          dw;
        int unsigned          dh;
        int unsigned          bpp;
        int unsigned          n;
        logic [5:0]           junk;
        logic [CFG_IDX_W-1:0] spoil;
        bit                   broken;
        sw = $urandom_range(1, 10);
        sh = $urandom_range(1, 10);
        if ($urandom_range(0, 11) == 0) begin
            sw = MAX_W;
            sh = 1;
        end else if ($urandom_range(0, 11) == 0) begin
            sw = 1;
            sh = MAX_H;
        end
        dw = $urandom_range(1, 12);
        dh = $urandom_range(1, 12);
        if ($urandom_range(0, 9) == 0) begin
            dw = MAX_W;
            dh = $urandom_range(1, 2);
        end else if ($urandom_range(0, 9) == 0) begin
            dw = $urandom_range(1, 2);
            dh = MAX_H;
        end
        bpp = $urandom_range(1, MAX_BPP);
        if ($urandom_range(0, 7) == 0) begin
            spoil = CFG_IDX_W'($urandom_range(0, 4));
            case (spoil)
                REG_SRC_WIDTH:  sw = bad_size();
                REG_SRC_HEIGHT: sh = bad_size();
                REG_DST_WIDTH:  dw = bad_size();
                REG_DST_HEIGHT: dh = bad_size();
                default:        bpp = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(5, 7);
            endcase
        end
        junk = 6'($urandom);
        gap_odds   = $urandom_range(0, 3) * 4;
        stall_odds = $urandom_range(0, 3) * 4;
        set_frame(sw, sh, dw, dh, {junk, BPP_W'(bpp)});

        broken = ($urandom_range(0, 4) == 0);
        if (!broken && cfg_ok) begin
            repeat (frame_px) put_pixel($urandom);
            rand_items += frame_px;
        end
        n = $urandom_range(10, 60);
        repeat (n) issue($urandom_range(0, 9) < (broken ? 4 : 8));
        rand_items += n;
        wait_idle();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        gap_odds   = 3;
        stall_odds = 3;

        // reset sizes: 1x1 to 1x1, one byte per pixel
        put_pixel(32'hFFFF_FFFF);
        take_pixel();
        take_pixel();
        wait_idle();

        // 2x2 to 3x1, three bytes; the fourth fetch wraps into a new frame
        set_frame(2, 2, 3, 1, CFG_W'(3));
        put_pixel(32'h0000_0000);
        put_pixel(32'hFFFF_FFFF);
        put_pixel(32'h8000_0001);
        put_pixel(32'h7FFF_FFFE);
        repeat (4) take_pixel();
        wait_idle();

        // one-column destination, bytes_per_pixel with junk in the upper bits
        set_frame(2, 2, 1, 3, {6'b101010, BPP_W'(4)});
        repeat (3) take_pixel();
        wait_idle();

        // invalid arguments: zero and oversized fields
        set_frame(2, 2, 1, 1, CFG_W'(0));
        take_pixel();
        wait_idle();
        set_frame(2, 2, 1, 1, CFG_W'(7));
        take_pixel();
        wait_idle();
        set_frame(0, 2, 1, 1, CFG_W'(1));
        take_pixel();
        wait_idle();
        set_frame(2, 2, 1, 0, CFG_W'(1));
        take_pixel();
        wait_idle();
        set_frame(2, 511, 1, 1, CFG_W'(1));
        take_pixel();
        wait_idle();
        set_frame(2, 2, MAX_W + 1, 1, CFG_W'(1));
        take_pixel();
        wait_idle();

        while (rand_items < RAND_ITEMS)
            random_phase();

        // full-width row, no idling; fetches run past the end of the frame
        gap_odds   = 0;
        stall_odds = 0;
        set_frame(MAX_W, 1, MAX_W, 1, CFG_W'(MAX_BPP));
        repeat (MAX_W) put_pixel($urandom);
        repeat (MAX_W + 8) take_pixel();
        wait_idle();
        set_frame(MAX_W, 1, 2, 2, CFG_W'(2));
        repeat (8) take_pixel();
        wait_idle();

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
